// ===== rtl/erl_pkg.sv =====
// Shared types and constants for the endpoint register and lookup block.
// No dependencies; erl_ctrl, erl_dp and the top level import this package.
package erl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_DEPTH);

  // result codes
  localparam logic [2:0] ST_REGISTERED = 3'd0;
  localparam logic [2:0] ST_MALFORMED  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_FOUND      = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL = 3'd5;

  // request kinds
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_LOOKUP   = 1'b1;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // field limits
  localparam logic [2:0]  PORT_FIELD   = 3'd4;
  localparam logic [2:0]  LAST_OCTET   = 3'd3;
  localparam logic [2:0]  OCTET_DIGITS = 3'd3;
  localparam logic [2:0]  PORT_DIGITS  = 3'd5;
  localparam logic [16:0] OCTET_MAX    = 17'd255;
  localparam logic [16:0] PORT_MAX     = 17'd65535;
  localparam logic [15:0] REQ_MAX      = 16'hFFFF;

  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic finish;   // close the request after its last character
    logic scan;     // step the table search
    logic commit;   // produce the result, store on register
  } erl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } erl_stat_t;

endpackage

// ===== rtl/erl_ifs.sv =====
// Valid/ready channel interfaces for the endpoint block.
// Depends on nothing; payload widths are fixed by the item format.
interface erl_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, operation, char_code, last_char, input ready);
  modport sink   (input valid, operation, char_code, last_char, output ready);
endinterface

interface erl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] match_request;

  modport source (output valid, status, match_request, input ready);
  modport sink   (input valid, status, match_request, output ready);
endinterface

// ===== rtl/erl_ctrl.sv =====
// Controller: sequences parse, request close, table search and result.
// Depends on erl_pkg.
module erl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  erl_pkg::erl_stat_t stat,
  output erl_pkg::erl_cmd_t  cmd
);
  import erl_pkg::*;

  localparam logic [1:0] S_PARSE  = 2'd0;
  localparam logic [1:0] S_FINAL  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_PARSE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        state_next = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.scan = 1'b1;
        if (stat.scan_done && stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_PARSE;
        end
      end
      default: begin
        state_next = S_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PARSE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/erl_dp.sv =====
// Datapath: character parser, request counter, endpoint table and result register.
// Depends on erl_pkg.
module erl_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               operation,
  input  logic [7:0]         char_code,
  input  logic               out_ready,
  input  erl_pkg::erl_cmd_t  cmd,
  output erl_pkg::erl_stat_t stat,
  output logic               out_valid,
  output logic [2:0]         status,
  output logic [15:0]        match_request
);
  import erl_pkg::*;

  // parser state
  logic [2:0]  field_index, field_index_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [16:0] field_value, field_value_next;
  logic        first_digit_zero, first_digit_zero_next;
  logic        malformed, malformed_next;
  logic [47:0] packed_ep, packed_ep_next;
  logic        kind, kind_next;
  logic        in_request;
  logic [15:0] req_cnt;

  // table
  logic [47:0] mem_ep  [TABLE_DEPTH];
  logic [15:0] mem_req [TABLE_DEPTH];
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] scan_idx;
  logic              rd_pending;
  logic [47:0]       rd_ep;
  logic [15:0]       rd_req;
  logic              hit;
  logic [15:0]       hit_req;
  logic              hit_now;
  logic              issue;
  logic              table_full;
  logic              do_store;
  logic [2:0]        status_next;

  logic       is_digit;
  logic [2:0] limit;
  logic [7:0] octet;

  always_comb begin
    if (in_request) begin
      field_index_next      = field_index;
      digit_count_next      = digit_count;
      field_value_next      = field_value;
      first_digit_zero_next = first_digit_zero;
      malformed_next        = malformed;
      packed_ep_next        = packed_ep;
      kind_next             = kind;
    end else begin
      field_index_next      = '0;
      digit_count_next      = '0;
      field_value_next      = '0;
      first_digit_zero_next = 1'b0;
      malformed_next        = 1'b0;
      packed_ep_next        = '0;
      kind_next             = operation;
    end

    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    limit    = (field_index_next >= PORT_FIELD) ? PORT_DIGITS : OCTET_DIGITS;
    octet    = field_value_next[7:0];

    if (is_digit) begin
      if (digit_count_next == '0) begin
        first_digit_zero_next = (char_code == CH_ZERO);
      end else if (first_digit_zero_next) begin
        malformed_next = 1'b1;
      end
      if (digit_count_next < limit) begin
        field_value_next = (field_value_next << 3) + (field_value_next << 1)
                           + {13'd0, char_code[3:0]};
        digit_count_next = digit_count_next + 3'd1;
      end else begin
        malformed_next = 1'b1;
      end
    end else if ((char_code == CH_DOT && field_index_next < LAST_OCTET) ||
                 (char_code == CH_COLON && field_index_next == LAST_OCTET)) begin
      if (digit_count_next == '0 || field_value_next > OCTET_MAX) begin
        malformed_next = 1'b1;
      end
      case (field_index_next)
        3'd0:    packed_ep_next[47:40] = octet;
        3'd1:    packed_ep_next[39:32] = octet;
        3'd2:    packed_ep_next[31:24] = octet;
        default: packed_ep_next[23:16] = octet;
      endcase
      field_index_next      = field_index_next + 3'd1;
      digit_count_next      = '0;
      field_value_next      = '0;
      first_digit_zero_next = 1'b0;
    end else begin
      malformed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index      <= '0;
      digit_count      <= '0;
      field_value      <= '0;
      first_digit_zero <= 1'b0;
      malformed        <= 1'b0;
      packed_ep        <= '0;
      kind             <= OP_REGISTER;
      in_request       <= 1'b0;
      req_cnt          <= '0;
    end else if (cmd.accept) begin
      field_index      <= field_index_next;
      digit_count      <= digit_count_next;
      field_value      <= field_value_next;
      first_digit_zero <= first_digit_zero_next;
      malformed        <= malformed_next;
      packed_ep        <= packed_ep_next;
      kind             <= kind_next;
      in_request       <= 1'b1;
    end else if (cmd.finish) begin
      // end of text: port field must be open and in range
      if (field_index != PORT_FIELD ||
          digit_count == '0 || field_value > PORT_MAX) begin
        malformed <= 1'b1;
      end
      if (field_index == PORT_FIELD) begin
        packed_ep[15:0] <= field_value[15:0];
      end
      in_request <= 1'b0;
      if (req_cnt != REQ_MAX) begin
        req_cnt <= req_cnt + 16'd1;
      end
    end
  end

  // linear search, one read issued per cycle, compare on registered data
  assign hit_now = rd_pending && (rd_ep == packed_ep);
  assign issue   = cmd.scan && !malformed && !hit && !hit_now && (scan_idx < fill_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      rd_pending <= 1'b0;
      hit        <= 1'b0;
    end else if (cmd.finish) begin
      scan_idx   <= '0;
      rd_pending <= 1'b0;
      hit        <= 1'b0;
    end else begin
      rd_pending <= issue;
      if (issue) begin
        scan_idx <= scan_idx + FILL_W'(1);
      end
      if (hit_now && !hit) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_now && !hit) begin
      hit_req <= rd_req;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ep  <= mem_ep[scan_idx[TBL_IDX_W-1:0]];
      rd_req <= mem_req[scan_idx[TBL_IDX_W-1:0]];
    end
  end

  assign table_full = (fill_count >= FILL_MAX);
  assign do_store   = cmd.commit && !malformed && kind == OP_REGISTER && !hit && !table_full;

  always_ff @(posedge clk) begin
    if (do_store) begin
      mem_ep[fill_count[TBL_IDX_W-1:0]]  <= packed_ep;
      mem_req[fill_count[TBL_IDX_W-1:0]] <= req_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (do_store) begin
      fill_count <= fill_count + FILL_W'(1);
    end
  end

  always_comb begin
    if (malformed) begin
      status_next = ST_MALFORMED;
    end else if (kind == OP_REGISTER) begin
      if (hit) begin
        status_next = ST_DUPLICATE;
      end else if (table_full) begin
        status_next = ST_TABLE_FULL;
      end else begin
        status_next = ST_REGISTERED;
      end
    end else if (hit) begin
      status_next = ST_FOUND;
    end else begin
      status_next = ST_NOT_FOUND;
    end
  end

  // result register, frees the parser while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status        <= status_next;
      match_request <= (status_next == ST_FOUND) ? hit_req : 16'd0;
    end
  end

  assign stat.scan_done = malformed || (!rd_pending && (hit || scan_idx >= fill_count));
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/endpoint_register_and_lookup.sv =====
// Endpoint register and lookup, top level. Depends on erl_pkg, erl_ifs, erl_ctrl, erl_dp.
// Throughput: one character per cycle; after the last character the parser is busy
//   while it closes the request and reads table entries in turn (up to the fill count),
//   as set by the single-port table read in the linear search.
// Result: registered once the search ends (on a hit, after the last entry read is compared,
//   or with no read), and held back while the output register stays occupied.
// Reset: synchronous; clears control, counter and fill count, leaving the table empty.
module endpoint_register_and_lookup (
  input  logic       clk,
  input  logic       rst,
  erl_in_if.sink     in_ch,
  erl_out_if.source  out_ch
);
  import erl_pkg::*;

  erl_cmd_t  cmd;
  erl_stat_t stat;

  erl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_char),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  erl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .operation     (in_ch.operation),
    .char_code     (in_ch.char_code),
    .out_ready     (out_ch.ready),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .status        (out_ch.status),
    .match_request (out_ch.match_request)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("result produced while output register still occupied");

  a_match_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_FOUND) |-> (out_ch.match_request == 16'd0))
    else $error("request number reported on a result other than found");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == ST_FOUND) |-> (out_ch.match_request != 16'd0))
    else $error("found result carries request number zero");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish || cmd.scan) |-> !in_ch.ready)
    else $error("input taken while a request is being closed");

endmodule
